### hw/rtl/sbm_pkg.sv
`timescale 1ns / 1ps
// Package for the servo bus master transaction engine.
// Holds sizes, opcodes, status codes and register indexes; depends on nothing.
package sbm_pkg;

    localparam int REPLY_DEPTH = 16;
    localparam int MAX_READ    = 10;

    localparam int AW        = $clog2(REPLY_DEPTH);
    localparam int CNT_W     = $clog2(REPLY_DEPTH + 2);
    localparam int EXP_W     = $clog2(MAX_READ + 7);
    localparam int LEN_W     = (CNT_W > EXP_W) ? CNT_W : EXP_W;
    localparam int RLEN_W    = $clog2(MAX_READ + 1);
    localparam int FRAME_MAX = 9;
    localparam int OPS_MAX   = FRAME_MAX - 4;
    localparam int SEQ_W     = $clog2(((MAX_READ > FRAME_MAX) ? MAX_READ : FRAME_MAX) + 1);

    localparam logic [7:0] PREAMBLE       = 8'hFF;
    localparam int         BASE_REPLY_LEN = 6;
    localparam int         DATA_OFFSET    = 5;
    localparam int         SUM_FIRST      = 2;

    localparam logic KIND_TX   = 1'b0;
    localparam logic KIND_DONE = 1'b1;

    typedef enum logic [2:0] {
        OP_COMMAND    = 3'd0,
        OP_WRITE_BYTE = 3'd1,
        OP_WRITE_WORD = 3'd2,
        OP_READ       = 3'd3,
        OP_RX_BYTE    = 3'd4,
        OP_LINE_IDLE  = 3'd5,
        OP_TICK       = 3'd6
    } op_t;

    typedef enum logic [1:0] {
        CFG_SERVO_ID      = 2'd0,
        CFG_REPLY_TIMEOUT = 2'd1,
        CFG_WRITE_INSTR   = 2'd2,
        CFG_READ_INSTR    = 2'd3
    } cfg_index_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_TIMEOUT  = 2'd1,
        ST_MISSING  = 2'd2,
        ST_CHECKSUM = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        PH_IDLE = 2'b01,
        PH_WAIT = 2'b10
    } phase_t;

    typedef enum logic [2:0] {
        SEQ_FRAME  = 3'b001,
        SEQ_STATUS = 3'b010,
        SEQ_DATA   = 3'b100
    } seq_mode_t;

endpackage

### hw/rtl/servo_bus_master_transaction.sv
`timescale 1ns / 1ps
// Servo bus master transaction engine: frame transmit, reply capture and completion.
// Depends on sbm_pkg. The reply bytes live in a one-port-write, one-port-read RAM.
// After an item's transfer, its results are loaded into the result sequencer and then registered in the output stage.
// Throughput: one result per cycle unless m_ready stalls the output; an item that causes
// results holds off the next item until the result sequencer has issued them all.
// Read data comes from the reply RAM, whose registered read port follows the output stage.
// Reset (aresetn low, synchronous) restores the register defaults and the idle phase;
// the reply RAM is not cleared and needs no clearing pass.
module servo_bus_master_transaction (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_op,
    input  logic [7:0]  s_command_code,
    input  logic [7:0]  s_address,
    input  logic [15:0] s_value,
    input  logic [3:0]  s_read_len,
    input  logic [7:0]  s_rx_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_kind,
    output logic [7:0]  m_tx_byte,
    output logic [1:0]  m_status,
    output logic [7:0]  m_data_byte,
    output logic        m_last
);

    logic [7:0]  servo_id_reg;
    logic [15:0] timeout_reg;
    logic [7:0]  winst_reg;
    logic [7:0]  rinst_reg;

    sbm_pkg::phase_t            phase_reg, phase_next;
    logic [sbm_pkg::LEN_W-1:0]  exp_len_reg, exp_len_next;
    logic [sbm_pkg::RLEN_W-1:0] pend_len_reg, pend_len_next;
    logic [sbm_pkg::LEN_W-1:0]  count_reg, count_next;
    logic [15:0]                ticks_reg, ticks_next;
    logic [7:0]                 sum_reg, sum_next;
    logic [7:0]                 chk_reg, chk_next;

    logic [sbm_pkg::SEQ_W-1:0]  seq_cnt_reg, seq_cnt_next;
    sbm_pkg::seq_mode_t         seq_mode_reg, seq_mode_next;
    logic [7:0]                 frame_reg [sbm_pkg::FRAME_MAX];
    logic [7:0]                 frame_next [sbm_pkg::FRAME_MAX];
    sbm_pkg::status_t           st_reg, st_next;
    logic [sbm_pkg::AW-1:0]     data_addr_reg, data_addr_next;

    logic                       out_valid_reg, out_valid_next;
    logic                       out_kind_reg, out_kind_next;
    logic [7:0]                 out_tx_reg, out_tx_next;
    sbm_pkg::status_t           out_status_reg, out_status_next;
    logic                       out_last_reg, out_last_next;
    logic                       out_is_data_reg, out_is_data_next;
    logic [sbm_pkg::AW-1:0]     rd_addr_reg, rd_addr_next;
    logic [7:0]                 rd_data_reg;

    logic [7:0]                 reply_mem [sbm_pkg::REPLY_DEPTH];
    logic                       mem_we;

    logic                       accept;
    logic                       is_request;
    logic                       gen;
    sbm_pkg::op_t               op;
    logic [7:0]                 ops [sbm_pkg::OPS_MAX];
    logic [2:0]                 nops;
    logic [sbm_pkg::RLEN_W-1:0] rlen_clamp;
    logic [7:0]                 len_byte;
    logic [7:0]                 chk_new;
    logic [7:0]                 frame_new [sbm_pkg::FRAME_MAX];
    logic [15:0]                ticks_inc;

    assign op          = sbm_pkg::op_t'(s_op);
    assign is_request  = !s_op[2];
    assign s_ready     = (seq_cnt_reg == '0);
    assign accept      = s_valid && s_ready;
    assign gen         = (seq_cnt_reg != '0) && (!out_valid_reg || m_ready);

    assign m_valid     = out_valid_reg;
    assign m_kind      = out_kind_reg;
    assign m_tx_byte   = out_tx_reg;
    assign m_status    = out_status_reg;
    assign m_last      = out_last_reg;
    assign m_data_byte = out_is_data_reg ? rd_data_reg : 8'h00;
    assign ticks_inc   = (ticks_reg == 16'hFFFF) ? ticks_reg : ticks_reg + 16'd1;

    always_comb begin
        if (s_read_len == 4'd0) begin
            rlen_clamp = sbm_pkg::RLEN_W'(1);
        end else if (int'(s_read_len) > sbm_pkg::MAX_READ) begin
            rlen_clamp = sbm_pkg::RLEN_W'(sbm_pkg::MAX_READ);
        end else begin
            rlen_clamp = sbm_pkg::RLEN_W'(s_read_len);
        end

        for (int i = 0; i < sbm_pkg::OPS_MAX; i++) begin
            ops[i] = 8'h00;
        end
        nops = 3'd0;
        unique case (op)
            sbm_pkg::OP_COMMAND: begin
                ops[0] = s_command_code;
                nops   = 3'd1;
            end
            sbm_pkg::OP_WRITE_BYTE: begin
                ops[0] = winst_reg;
                ops[1] = s_address;
                ops[2] = s_value[7:0];
                nops   = 3'd3;
            end
            sbm_pkg::OP_WRITE_WORD: begin
                ops[0] = winst_reg;
                ops[1] = s_address;
                ops[2] = s_value[7:0];
                ops[3] = s_value[15:8];
                nops   = 3'd4;
            end
            default: begin
                ops[0] = rinst_reg;
                ops[1] = s_address;
                ops[2] = 8'(rlen_clamp);
                nops   = 3'd3;
            end
        endcase

        len_byte = 8'(nops) + 8'd1;
        chk_new  = ~(servo_id_reg + len_byte + ops[0] + ops[1] + ops[2] + ops[3]);

        frame_new[0] = sbm_pkg::PREAMBLE;
        frame_new[1] = sbm_pkg::PREAMBLE;
        frame_new[2] = servo_id_reg;
        frame_new[3] = len_byte;
        for (int i = 0; i < sbm_pkg::OPS_MAX; i++) begin
            frame_new[4 + i] = (i < int'(nops)) ? ops[i] : chk_new;
        end
    end

    always_comb begin
        phase_next       = phase_reg;
        exp_len_next     = exp_len_reg;
        pend_len_next    = pend_len_reg;
        count_next       = count_reg;
        ticks_next       = ticks_reg;
        sum_next         = sum_reg;
        chk_next         = chk_reg;
        seq_cnt_next     = seq_cnt_reg;
        seq_mode_next    = seq_mode_reg;
        frame_next       = frame_reg;
        st_next          = st_reg;
        data_addr_next   = data_addr_reg;
        out_valid_next   = out_valid_reg;
        out_kind_next    = out_kind_reg;
        out_tx_next      = out_tx_reg;
        out_status_next  = out_status_reg;
        out_last_next    = out_last_reg;
        out_is_data_next = out_is_data_reg;
        rd_addr_next     = rd_addr_reg;
        mem_we           = 1'b0;

        if (out_valid_reg && m_ready) begin
            out_valid_next = 1'b0;
        end

        if (gen) begin
            out_valid_next   = 1'b1;
            seq_cnt_next     = seq_cnt_reg - sbm_pkg::SEQ_W'(1);
            out_last_next    = (seq_cnt_reg == sbm_pkg::SEQ_W'(1));
            out_tx_next      = 8'h00;
            out_status_next  = sbm_pkg::ST_OK;
            out_is_data_next = 1'b0;
            unique case (seq_mode_reg)
                sbm_pkg::SEQ_FRAME: begin
                    out_kind_next = sbm_pkg::KIND_TX;
                    out_tx_next   = frame_reg[0];
                    for (int k = 0; k < sbm_pkg::FRAME_MAX - 1; k++) begin
                        frame_next[k] = frame_reg[k + 1];
                    end
                end
                sbm_pkg::SEQ_STATUS: begin
                    out_kind_next   = sbm_pkg::KIND_DONE;
                    out_status_next = st_reg;
                end
                sbm_pkg::SEQ_DATA: begin
                    out_kind_next    = sbm_pkg::KIND_DONE;
                    out_is_data_next = 1'b1;
                    rd_addr_next     = data_addr_reg;
                    data_addr_next   = data_addr_reg + sbm_pkg::AW'(1);
                end
                default: begin
                    out_kind_next = sbm_pkg::KIND_DONE;
                end
            endcase
        end

        if (accept) begin
            if (is_request) begin
                if (phase_reg == sbm_pkg::PH_IDLE) begin
                    phase_next    = sbm_pkg::PH_WAIT;
                    frame_next    = frame_new;
                    seq_mode_next = sbm_pkg::SEQ_FRAME;
                    seq_cnt_next  = sbm_pkg::SEQ_W'(nops) + sbm_pkg::SEQ_W'(5);
                    count_next    = '0;
                    ticks_next    = 16'd0;
                    sum_next      = 8'h00;
                    chk_next      = 8'h00;
                    if (op == sbm_pkg::OP_READ) begin
                        exp_len_next  = sbm_pkg::LEN_W'(sbm_pkg::BASE_REPLY_LEN)
                                      + sbm_pkg::LEN_W'(rlen_clamp);
                        pend_len_next = rlen_clamp;
                    end else begin
                        exp_len_next  = sbm_pkg::LEN_W'(sbm_pkg::BASE_REPLY_LEN);
                        pend_len_next = '0;
                    end
                end
            end else if (phase_reg == sbm_pkg::PH_WAIT) begin
                unique case (op)
                    sbm_pkg::OP_RX_BYTE: begin
                        if (count_reg < sbm_pkg::LEN_W'(sbm_pkg::REPLY_DEPTH)) begin
                            mem_we = 1'b1;
                        end
                        if (count_reg < sbm_pkg::LEN_W'(sbm_pkg::REPLY_DEPTH + 1)) begin
                            count_next = count_reg + sbm_pkg::LEN_W'(1);
                        end
                        if (count_reg >= sbm_pkg::LEN_W'(sbm_pkg::SUM_FIRST) &&
                            count_reg + sbm_pkg::LEN_W'(1) < exp_len_reg) begin
                            sum_next = sum_reg + s_rx_byte;
                        end
                        if (count_reg + sbm_pkg::LEN_W'(1) == exp_len_reg) begin
                            chk_next = s_rx_byte;
                        end
                    end
                    sbm_pkg::OP_LINE_IDLE: begin
                        phase_next    = sbm_pkg::PH_IDLE;
                        seq_mode_next = sbm_pkg::SEQ_STATUS;
                        seq_cnt_next  = sbm_pkg::SEQ_W'(1);
                        if (count_reg != exp_len_reg) begin
                            st_next = sbm_pkg::ST_MISSING;
                        end else if (~sum_reg != chk_reg) begin
                            st_next = sbm_pkg::ST_CHECKSUM;
                        end else if (pend_len_reg == '0) begin
                            st_next = sbm_pkg::ST_OK;
                        end else begin
                            st_next        = sbm_pkg::ST_OK;
                            seq_mode_next  = sbm_pkg::SEQ_DATA;
                            seq_cnt_next   = sbm_pkg::SEQ_W'(pend_len_reg);
                            data_addr_next = sbm_pkg::AW'(sbm_pkg::DATA_OFFSET);
                        end
                    end
                    sbm_pkg::OP_TICK: begin
                        ticks_next = ticks_inc;
                        if (ticks_inc >= timeout_reg) begin
                            phase_next    = sbm_pkg::PH_IDLE;
                            seq_mode_next = sbm_pkg::SEQ_STATUS;
                            seq_cnt_next  = sbm_pkg::SEQ_W'(1);
                            st_next       = sbm_pkg::ST_TIMEOUT;
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            servo_id_reg <= 8'd1;
            timeout_reg  <= 16'd100;
            winst_reg    <= 8'd3;
            rinst_reg    <= 8'd2;
        end else if (cfg_wr_en) begin
            unique case (sbm_pkg::cfg_index_t'(cfg_index))
                sbm_pkg::CFG_SERVO_ID:      servo_id_reg <= cfg_wr_data[7:0];
                sbm_pkg::CFG_REPLY_TIMEOUT: timeout_reg  <= cfg_wr_data;
                sbm_pkg::CFG_WRITE_INSTR:   winst_reg    <= cfg_wr_data[7:0];
                sbm_pkg::CFG_READ_INSTR:    rinst_reg    <= cfg_wr_data[7:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= sbm_pkg::PH_IDLE;
            exp_len_reg   <= '0;
            pend_len_reg  <= '0;
            count_reg     <= '0;
            ticks_reg     <= 16'd0;
            seq_cnt_reg   <= '0;
            seq_mode_reg  <= sbm_pkg::SEQ_FRAME;
            out_valid_reg <= 1'b0;
        end else begin
            phase_reg     <= phase_next;
            exp_len_reg   <= exp_len_next;
            pend_len_reg  <= pend_len_next;
            count_reg     <= count_next;
            ticks_reg     <= ticks_next;
            seq_cnt_reg   <= seq_cnt_next;
            seq_mode_reg  <= seq_mode_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        sum_reg         <= sum_next;
        chk_reg         <= chk_next;
        frame_reg       <= frame_next;
        st_reg          <= st_next;
        data_addr_reg   <= data_addr_next;
        out_kind_reg    <= out_kind_next;
        out_tx_reg      <= out_tx_next;
        out_status_reg  <= out_status_next;
        out_last_reg    <= out_last_next;
        out_is_data_reg <= out_is_data_next;
        rd_addr_reg     <= rd_addr_next;
    end

    // The read port follows the output stage, so a stalled data transfer keeps its byte.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            reply_mem[count_reg[sbm_pkg::AW-1:0]] <= s_rx_byte;
        end
        rd_data_reg <= reply_mem[rd_addr_next];
    end

    a_no_write_during_run: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |-> (seq_cnt_reg == '0))
        else $error("Reply RAM written while the result sequencer is running.");

    a_done_when_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (gen && (seq_mode_reg != sbm_pkg::SEQ_FRAME)) |-> (phase_reg == sbm_pkg::PH_IDLE))
        else $error("Completion transfer generated while a reply is still awaited.");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= sbm_pkg::LEN_W'(sbm_pkg::REPLY_DEPTH + 1))
        else $error("Reply count ran past its saturation value.");

    a_data_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_is_data_reg && !m_ready) |=> $stable(rd_data_reg))
        else $error("Read data changed under a stalled data transfer.");

endmodule

### bench/sbm_bus_checker.sv
`timescale 1ns / 1ps
// Checker for the servo bus master bench: predicts frames and completions from every input transfer.
// It compares each result transfer in order and reports the failure count. Depends on sbm_pkg.
module sbm_bus_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_wr_data,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [2:0]  s_op,
    input  logic [7:0]  s_command_code,
    input  logic [7:0]  s_address,
    input  logic [15:0] s_value,
    input  logic [3:0]  s_read_len,
    input  logic [7:0]  s_rx_byte,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic        m_kind,
    input  logic [7:0]  m_tx_byte,
    input  logic [1:0]  m_status,
    input  logic [7:0]  m_data_byte,
    input  logic        m_last,
    output int          fail_count,
    output int          pending
);

    typedef struct packed {
        logic       kind;
        logic [7:0] tx_byte;
        logic [1:0] status;
        logic [7:0] data_byte;
        logic       last;
    } bus_result_t;

    bus_result_t results_due [$];

    logic [7:0]  cur_servo_id;
    logic [15:0] cur_timeout;
    logic [7:0]  cur_write_instr;
    logic [7:0]  cur_read_instr;

    sbm_pkg::phase_t txn_phase;
    int          reply_len_exp;
    int          reply_cnt;
    int          read_len_pend;
    logic [15:0] tick_cnt;
    logic [7:0]  reply_bytes [sbm_pkg::REPLY_DEPTH];

    function automatic string describe(input bus_result_t r);
        return $sformatf("kind=%0d tx_byte=%02h status=%0d data_byte=%02h last=%0d",
                         r.kind, r.tx_byte, r.status, r.data_byte, r.last);
    endfunction

    function automatic void emit_result(input logic kind, input logic [7:0] tx,
                                        input logic [1:0] status, input logic [7:0] data,
                                        input logic last);
        bus_result_t r;
        r.kind      = kind;
        r.tx_byte   = tx;
        r.status    = status;
        r.data_byte = data;
        r.last      = last;
        results_due.push_back(r);
    endfunction

    function automatic void start_frame(input logic [31:0] operands, input int n_ops,
                                        input int reply_len, input int rlen);
        logic [7:0] len;
        logic [7:0] sum;
        logic [7:0] b;
        int         i;
        len = 8'(n_ops + 1);
        sum = cur_servo_id + len;
        emit_result(sbm_pkg::KIND_TX, sbm_pkg::PREAMBLE, sbm_pkg::ST_OK, 8'h00, 1'b0);
        emit_result(sbm_pkg::KIND_TX, sbm_pkg::PREAMBLE, sbm_pkg::ST_OK, 8'h00, 1'b0);
        emit_result(sbm_pkg::KIND_TX, cur_servo_id, sbm_pkg::ST_OK, 8'h00, 1'b0);
        emit_result(sbm_pkg::KIND_TX, len, sbm_pkg::ST_OK, 8'h00, 1'b0);
        for (i = 0; i < n_ops; i++) begin
            b = operands[8*i +: 8];
            emit_result(sbm_pkg::KIND_TX, b, sbm_pkg::ST_OK, 8'h00, 1'b0);
            sum = sum + b;
        end
        emit_result(sbm_pkg::KIND_TX, sum ^ 8'hFF, sbm_pkg::ST_OK, 8'h00, 1'b1);
        txn_phase     = sbm_pkg::PH_WAIT;
        reply_len_exp = reply_len;
        read_len_pend = rlen;
        reply_cnt     = 0;
        tick_cnt      = '0;
    endfunction

    function automatic void close_transaction();
        logic [7:0] sum;
        int         i;
        txn_phase = sbm_pkg::PH_IDLE;
        sum = 8'h00;
        if (reply_cnt != reply_len_exp || reply_len_exp < 2) begin
            emit_result(sbm_pkg::KIND_DONE, 8'h00, sbm_pkg::ST_MISSING, 8'h00, 1'b1);
        end else begin
            for (i = sbm_pkg::SUM_FIRST; i + 1 < reply_len_exp; i++)
                sum = sum + reply_bytes[i];
            if ((sum ^ 8'hFF) != reply_bytes[reply_len_exp - 1]) begin
                emit_result(sbm_pkg::KIND_DONE, 8'h00, sbm_pkg::ST_CHECKSUM, 8'h00, 1'b1);
            end else if (read_len_pend == 0) begin
                emit_result(sbm_pkg::KIND_DONE, 8'h00, sbm_pkg::ST_OK, 8'h00, 1'b1);
            end else begin
                for (i = 0; i < read_len_pend; i++)
                    emit_result(sbm_pkg::KIND_DONE, 8'h00, sbm_pkg::ST_OK,
                                reply_bytes[sbm_pkg::DATA_OFFSET + i],
                                (i + 1 == read_len_pend));
            end
        end
    endfunction

    function automatic void engine_step(input logic [2:0] op, input logic [7:0] cmd,
                                        input logic [7:0] addr, input logic [15:0] val,
                                        input logic [3:0] rlen, input logic [7:0] rx);
        logic [3:0] len_adj;
        if (rlen == 4'd0)
            len_adj = 4'd1;
        else if (rlen > 4'(sbm_pkg::MAX_READ))
            len_adj = 4'(sbm_pkg::MAX_READ);
        else
            len_adj = rlen;
        case (op)
            sbm_pkg::OP_COMMAND: begin
                if (txn_phase == sbm_pkg::PH_IDLE)
                    start_frame({24'h0, cmd}, 1, sbm_pkg::BASE_REPLY_LEN, 0);
            end
            sbm_pkg::OP_WRITE_BYTE: begin
                if (txn_phase == sbm_pkg::PH_IDLE)
                    start_frame({8'h00, val[7:0], addr, cur_write_instr}, 3,
                                sbm_pkg::BASE_REPLY_LEN, 0);
            end
            sbm_pkg::OP_WRITE_WORD: begin
                if (txn_phase == sbm_pkg::PH_IDLE)
                    start_frame({val[15:8], val[7:0], addr, cur_write_instr}, 4,
                                sbm_pkg::BASE_REPLY_LEN, 0);
            end
            sbm_pkg::OP_READ: begin
                if (txn_phase == sbm_pkg::PH_IDLE)
                    start_frame({8'h00, 4'h0, len_adj, addr, cur_read_instr}, 3,
                                sbm_pkg::BASE_REPLY_LEN + int'(len_adj), int'(len_adj));
            end
            sbm_pkg::OP_RX_BYTE: begin
                if (txn_phase == sbm_pkg::PH_WAIT) begin
                    if (reply_cnt < sbm_pkg::REPLY_DEPTH)
                        reply_bytes[reply_cnt] = rx;
                    if (reply_cnt < sbm_pkg::REPLY_DEPTH + 1)
                        reply_cnt++;
                end
            end
            sbm_pkg::OP_LINE_IDLE: begin
                if (txn_phase == sbm_pkg::PH_WAIT)
                    close_transaction();
            end
            sbm_pkg::OP_TICK: begin
                if (txn_phase == sbm_pkg::PH_WAIT) begin
                    if (tick_cnt != 16'hFFFF)
                        tick_cnt = tick_cnt + 16'd1;
                    if (tick_cnt >= cur_timeout) begin
                        txn_phase = sbm_pkg::PH_IDLE;
                        emit_result(sbm_pkg::KIND_DONE, 8'h00, sbm_pkg::ST_TIMEOUT,
                                    8'h00, 1'b1);
                    end
                end
            end
            default: begin
            end
        endcase
    endfunction

    function automatic void check_output();
        bus_result_t got;
        bus_result_t want;
        got.kind      = m_kind;
        got.tx_byte   = m_tx_byte;
        got.status    = m_status;
        got.data_byte = m_data_byte;
        got.last      = m_last;
        if (results_due.size() == 0) begin
            fail_count++;
            if (fail_count <= 10)
                $display("%0t: result transfer with nothing pending: %s", $time, describe(got));
        end else begin
            want = results_due.pop_front();
            if (got !== want) begin
                fail_count++;
                if (fail_count <= 10)
                    $display("%0t: result differs: expected %s, actual %s",
                             $time, describe(want), describe(got));
            end
        end
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            cur_servo_id    = 8'd1;
            cur_timeout     = 16'd100;
            cur_write_instr = 8'd3;
            cur_read_instr  = 8'd2;
            txn_phase       = sbm_pkg::PH_IDLE;
            reply_len_exp   = 0;
            reply_cnt       = 0;
            read_len_pend   = 0;
            tick_cnt        = '0;
            fail_count      = 0;
            results_due.delete();
        end else begin
            if (m_valid && m_ready)
                check_output();
            if (cfg_wr_en) begin
                case (cfg_index)
                    sbm_pkg::CFG_SERVO_ID:      cur_servo_id    = cfg_wr_data[7:0];
                    sbm_pkg::CFG_REPLY_TIMEOUT: cur_timeout     = cfg_wr_data;
                    sbm_pkg::CFG_WRITE_INSTR:   cur_write_instr = cfg_wr_data[7:0];
                    sbm_pkg::CFG_READ_INSTR:    cur_read_instr  = cfg_wr_data[7:0];
                    default: begin
                    end
                endcase
            end
            if (s_valid && s_ready)
                engine_step(s_op, s_command_code, s_address, s_value, s_read_len, s_rx_byte);
        end
        pending <= results_due.size();
    end

endmodule

### bench/tb_servo_bus_master_transaction.sv
`timescale 1ns / 1ps
// Bench top for servo_bus_master_transaction: clock, reset, register writes and request,
// reply-byte and tick traffic with random gaps. Depends on sbm_pkg and sbm_bus_checker.
module tb_servo_bus_master_transaction;

    localparam int         RANDOM_ITEMS = 450;
    localparam int         N_PHASES     = 6;
    localparam int         SETTLE       = 16;
    localparam int         CYCLE_LIMIT  = 400000;
    localparam logic [2:0] OP_UNUSED    = 3'd7;

    logic        aclk;
    logic        aresetn;
    logic        cfg_wr_en;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_wr_data;
    logic        s_valid;
    logic        s_ready;
    logic [2:0]  s_op;
    logic [7:0]  s_command_code;
    logic [7:0]  s_address;
    logic [15:0] s_value;
    logic [3:0]  s_read_len;
    logic [7:0]  s_rx_byte;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic        m_kind;
    logic [7:0]  m_tx_byte;
    logic [1:0]  m_status;
    logic [7:0]  m_data_byte;
    logic        m_last;

    int          fail_count;
    int          pending;
    int          cycle_count = 0;
    int          items_sent;
    int          ready_hold;
    int          cur_timeout;
    logic [7:0]  cur_sid;
    bit          tx_steady;
    bit          rx_steady;

    servo_bus_master_transaction i_dut (.*);

    sbm_bus_checker i_checker (.*);

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready    <= 1'b0;
            ready_hold <= 0;
        end else if (ready_hold > 0) begin
            m_ready    <= 1'b0;
            ready_hold <= ready_hold - 1;
        end else if (!rx_steady && $urandom_range(0, 3) == 0) begin
            m_ready    <= 1'b0;
            ready_hold <= pick_gap();
        end else begin
            m_ready <= 1'b1;
        end
    end

    task automatic send_item(input logic [2:0] op, input logic [7:0] cmd,
                             input logic [7:0] addr, input logic [15:0] val,
                             input logic [3:0] rlen, input logic [7:0] rx);
        int gap;
        gap = tx_steady ? 0 : pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_op           <= op;
        s_command_code <= cmd;
        s_address      <= addr;
        s_value        <= val;
        s_read_len     <= rlen;
        s_rx_byte      <= rx;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic send_rx(input logic [7:0] b);
        send_item(sbm_pkg::OP_RX_BYTE, 8'($urandom), 8'($urandom), 16'($urandom),
                  4'($urandom), b);
        items_sent++;
    endtask

    task automatic send_ctrl(input logic [2:0] op);
        send_item(op, 8'($urandom), 8'($urandom), 16'($urandom), 4'($urandom), 8'($urandom));
        items_sent++;
    endtask

    task automatic send_request(input logic [2:0] op, input logic [3:0] rlen);
        send_item(op, 8'($urandom), 8'($urandom), 16'($urandom), rlen, 8'($urandom));
        items_sent++;
    endtask

    task automatic wait_results_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    task automatic drain_block();
        wait_results_drained();
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_config(input logic [7:0] sid, input logic [15:0] timeout_ticks,
                                input logic [7:0] winstr, input logic [7:0] rinstr);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= sbm_pkg::CFG_SERVO_ID;
        cfg_wr_data <= {8'($urandom), sid};
        @(posedge aclk);
        cfg_index   <= sbm_pkg::CFG_REPLY_TIMEOUT;
        cfg_wr_data <= timeout_ticks;
        @(posedge aclk);
        cfg_index   <= sbm_pkg::CFG_WRITE_INSTR;
        cfg_wr_data <= {8'($urandom), winstr};
        @(posedge aclk);
        cfg_index   <= sbm_pkg::CFG_READ_INSTR;
        cfg_wr_data <= {8'($urandom), rinstr};
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        cur_sid     = sid;
        cur_timeout = int'(timeout_ticks);
    endtask

    task automatic run_directed();
        send_item(sbm_pkg::OP_TICK, 8'h00, 8'h00, 16'h0000, 4'h0, 8'h00);
        send_item(sbm_pkg::OP_RX_BYTE, 8'hFF, 8'hFF, 16'hFFFF, 4'hF, 8'hFF);
        send_item(sbm_pkg::OP_LINE_IDLE, 8'h00, 8'h00, 16'h0000, 4'h0, 8'h00);
        send_item(OP_UNUSED, 8'hFF, 8'hFF, 16'hFFFF, 4'hF, 8'hFF);
        send_item(sbm_pkg::OP_COMMAND, 8'hFF, 8'h00, 16'h0000, 4'h0, 8'h00);
        send_ctrl(sbm_pkg::OP_LINE_IDLE);
        send_item(sbm_pkg::OP_WRITE_BYTE, 8'h00, 8'h00, 16'hFFFF, 4'hF, 8'hFF);
        send_item(sbm_pkg::OP_READ, 8'h00, 8'h00, 16'h0000, 4'h3, 8'h00);
        send_rx(8'hFF);
        send_ctrl(sbm_pkg::OP_LINE_IDLE);
        send_item(sbm_pkg::OP_WRITE_WORD, 8'h00, 8'hFF, 16'hFFFF, 4'h0, 8'h00);
        send_ctrl(sbm_pkg::OP_LINE_IDLE);
        // A read length of zero asks for one byte; the reply carries 5A and a valid checksum.
        send_item(sbm_pkg::OP_READ, 8'hFF, 8'hA5, 16'h0000, 4'h0, 8'h00);
        send_rx(8'hFF);
        send_rx(8'hFF);
        send_rx(8'h01);
        send_rx(8'h03);
        send_rx(8'h00);
        send_rx(8'h5A);
        send_rx(8'hA1);
        send_ctrl(sbm_pkg::OP_LINE_IDLE);
        send_item(sbm_pkg::OP_READ, 8'h00, 8'h00, 16'hFFFF, 4'hF, 8'hFF);
        send_ctrl(sbm_pkg::OP_LINE_IDLE);
    endtask

    task automatic run_transaction();
        logic [7:0] reply [20];
        logic [7:0] sum;
        logic [2:0] req_op;
        logic [3:0] rlen;
        int         sel;
        int         n;
        int         n_send;
        int         k;
        int         mode;
        int         ticks;
        if ($urandom_range(0, 19) == 0)
            wait_results_drained();
        req_op = 3'($urandom_range(0, 3));
        sel = $urandom_range(0, 9);
        if (sel < 8)
            rlen = 4'($urandom_range(1, sbm_pkg::MAX_READ));
        else if (sel == 8)
            rlen = 4'd0;
        else
            rlen = 4'($urandom_range(sbm_pkg::MAX_READ + 1, 15));
        send_request(req_op, rlen);
        n = sbm_pkg::BASE_REPLY_LEN;
        if (req_op == sbm_pkg::OP_READ)
            n += (rlen == 4'd0) ? 1 :
                 (rlen > 4'(sbm_pkg::MAX_READ)) ? sbm_pkg::MAX_READ : int'(rlen);
        if ($urandom_range(0, 9) == 0)
            send_item(3'($urandom_range(0, 3)), 8'($urandom), 8'($urandom), 16'($urandom),
                      4'($urandom), 8'($urandom));
        reply[0] = sbm_pkg::PREAMBLE;
        reply[1] = sbm_pkg::PREAMBLE;
        reply[2] = cur_sid;
        reply[3] = 8'(n - 4);
        reply[4] = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'h00;
        for (k = 5; k < 20; k++)
            reply[k] = 8'($urandom);
        sum = reply[2] + reply[3] + reply[4];
        for (k = 5; k < n - 1; k++)
            sum = sum + reply[k];
        reply[n - 1] = ~sum;
        mode = $urandom_range(0, 19);
        n_send = n;
        if (mode < 3)
            reply[n - 1] = reply[n - 1] ^ 8'($urandom_range(1, 255));
        else if (mode < 5)
            n_send = $urandom_range(0, n - 1);
        else if (mode < 7)
            n_send = $urandom_range(n + 1, 20);
        else if (mode < 9)
            n_send = $urandom_range(0, n);
        for (k = 0; k < n_send; k++) begin
            if ($urandom_range(0, 19) == 0)
                send_ctrl(sbm_pkg::OP_TICK);
            send_rx(reply[k]);
        end
        if (mode >= 7 && mode < 9) begin
            if (cur_timeout <= 40)
                ticks = (cur_timeout == 0) ? 1 : cur_timeout;
            else
                ticks = $urandom_range(1, 8);
            repeat (ticks) send_ctrl(sbm_pkg::OP_TICK);
            if (cur_timeout > 40)
                send_ctrl(sbm_pkg::OP_LINE_IDLE);
        end else begin
            send_ctrl(sbm_pkg::OP_LINE_IDLE);
        end
        if ($urandom_range(0, 9) == 0)
            send_item(3'($urandom_range(4, 7)), 8'($urandom), 8'($urandom), 16'($urandom),
                      4'($urandom), 8'($urandom));
    endtask

    initial begin
        int ph;
        aresetn        = 1'b0;
        cfg_wr_en      = 1'b0;
        cfg_index      = sbm_pkg::CFG_SERVO_ID;
        cfg_wr_data    = 16'h0000;
        s_valid        = 1'b0;
        s_op           = sbm_pkg::OP_COMMAND;
        s_command_code = 8'h00;
        s_address      = 8'h00;
        s_value        = 16'h0000;
        s_read_len     = 4'h0;
        s_rx_byte      = 8'h00;
        tx_steady      = 1'b0;
        rx_steady      = 1'b0;
        cur_sid        = 8'd1;
        cur_timeout    = 100;
        items_sent     = 0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        run_directed();
        drain_block();
        items_sent = 0;
        for (ph = 0; ph < N_PHASES; ph++) begin
            case (ph)
                0: write_config(8'h00, 16'd1, 8'h00, 8'h00);
                1: write_config(8'hFF, 16'hFFFF, 8'hFF, 8'hFF);
                2: write_config(8'($urandom), 16'd0, 8'($urandom), 8'($urandom));
                default: write_config(8'($urandom), 16'($urandom_range(2, 12)),
                                      8'($urandom), 8'($urandom));
            endcase
            tx_steady = (ph == 3);
            rx_steady <= (ph == 4);
            while (items_sent < (ph + 1) * RANDOM_ITEMS / N_PHASES)
                run_transaction();
            drain_block();
        end
        @(negedge aclk);
        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
